[sv/sia_pkg.sv]
// Shared types and constants for the slot identifier allocator.
package sia_pkg;

    localparam int ID_W         = 10;
    localparam int USED_W       = 11;
    localparam int STAT_W       = 2;
    localparam int DEF_CAPACITY = 1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE         = 2'd0,
        ST_REJECT       = 2'd1,
        ST_ALREADY_FREE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // memory write strobes and valid-bit write data
    typedef struct packed {
        logic valid_we;
        logic valid_wd;
        logic stack_we;
    } t_wr_ctl;

endpackage

[sv/slot_id_allocator_with_holes.sv]
// Top level of the slot identifier allocator with a stack of freed slots.
// A transaction taken at an edge moves the sequencer to its execute state, and the result
//   strobe is registered from there; the receiver cannot stall.
// No new transaction is taken while busy, since the read at accept and the write back at
//   the end of the single execute cycle must both finish first.
// Reset: synchronous, active low; clears the counts and the sequencer with no clearing
//   pass, since every valid bit below the used count was written since reset.
module slot_id_allocator_with_holes #(
    parameter int CAPACITY = sia_pkg::DEF_CAPACITY
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_op,
    input  logic [sia_pkg::ID_W-1:0]   i_slot_id,
    output logic                       o_valid,
    output logic [sia_pkg::STAT_W-1:0] o_status,
    output logic [sia_pkg::ID_W-1:0]   o_given_id,
    output logic [sia_pkg::USED_W-1:0] o_used_count,
    output logic [sia_pkg::ID_W-1:0]   o_free_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                       accept;
    logic [AW-1:0]              valid_raddr;
    logic [AW-1:0]              stack_raddr;
    sia_pkg::t_wr_ctl           wr;
    logic [AW-1:0]              valid_waddr;
    logic [AW-1:0]              stack_waddr;
    logic [sia_pkg::ID_W-1:0]   stack_wdata;
    logic                       valid_rdata;
    logic [sia_pkg::ID_W-1:0]   stack_rdata;
    logic                       res_valid;
    sia_pkg::t_status           res_status;
    logic [sia_pkg::ID_W-1:0]   res_id;
    logic [sia_pkg::USED_W-1:0] res_used;
    logic [sia_pkg::ID_W-1:0]   res_free;

    logic                       r_valid;
    logic [sia_pkg::STAT_W-1:0] r_status;
    logic [sia_pkg::ID_W-1:0]   r_given_id;
    logic [sia_pkg::USED_W-1:0] r_used_count;
    logic [sia_pkg::ID_W-1:0]   r_free_count;

    // a transaction is taken whenever start meets an idle sequencer
    assign accept = start && !busy;

    sia_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_slot_id    (i_slot_id),
        .o_busy       (busy),
        .o_valid_raddr(valid_raddr),
        .o_stack_raddr(stack_raddr),
        .o_wr         (wr),
        .o_valid_waddr(valid_waddr),
        .o_stack_waddr(stack_waddr),
        .o_stack_wdata(stack_wdata),
        .i_valid_rdata(valid_rdata),
        .i_stack_rdata(stack_rdata),
        .o_res_valid  (res_valid),
        .o_res_status (res_status),
        .o_res_id     (res_id),
        .o_res_used   (res_used),
        .o_res_free   (res_free)
    );

    // both reads are issued at accept, so the execute cycle sees data that no
    // write can overlap: writes only happen at the end of execute, while busy
    sia_store #(
        .CAPACITY(CAPACITY)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_en      (accept),
        .i_valid_raddr(valid_raddr),
        .i_stack_raddr(stack_raddr),
        .i_wr         (wr),
        .i_valid_waddr(valid_waddr),
        .i_stack_waddr(stack_waddr),
        .i_stack_wdata(stack_wdata),
        .o_valid_rdata(valid_rdata),
        .o_stack_rdata(stack_rdata)
    );

    // hold the result for its one strobe cycle; the strobe alone needs reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_status     <= res_status;
            r_given_id   <= res_id;
            r_used_count <= res_used;
            r_free_count <= res_free;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_given_id   = r_given_id;
    assign o_used_count = r_used_count;
    assign o_free_count = r_free_count;

endmodule

[sv/sia_store.sv]
// Slot valid-bit memory and freed-slot stack memory, with registered reads.
module sia_store #(
    parameter int CAPACITY = sia_pkg::DEF_CAPACITY,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_valid_raddr,
    input  logic [AW-1:0]             i_stack_raddr,
    input  sia_pkg::t_wr_ctl          i_wr,
    input  logic [AW-1:0]             i_valid_waddr,
    input  logic [AW-1:0]             i_stack_waddr,
    input  logic [sia_pkg::ID_W-1:0]  i_stack_wdata,
    output logic                      o_valid_rdata,
    output logic [sia_pkg::ID_W-1:0]  o_stack_rdata
);

    logic                     r_valid_mem [CAPACITY];
    logic [sia_pkg::ID_W-1:0] r_stack_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_wr.valid_we) begin
            r_valid_mem[i_valid_waddr] <= i_wr.valid_wd;
        end
        if (i_rd_en) begin
            o_valid_rdata <= r_valid_mem[i_valid_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.stack_we) begin
            r_stack_mem[i_stack_waddr] <= i_stack_wdata;
        end
        if (i_rd_en) begin
            o_stack_rdata <= r_stack_mem[i_stack_raddr];
        end
    end

endmodule

[sv/sia_ctrl.sv]
// Sequencer and read-modify-write datapath for the slot identifier allocator.
module sia_ctrl #(
    parameter int CAPACITY = sia_pkg::DEF_CAPACITY,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_op,
    input  logic [sia_pkg::ID_W-1:0]   i_slot_id,
    output logic                       o_busy,
    output logic [AW-1:0]              o_valid_raddr,
    output logic [AW-1:0]              o_stack_raddr,
    output sia_pkg::t_wr_ctl           o_wr,
    output logic [AW-1:0]              o_valid_waddr,
    output logic [AW-1:0]              o_stack_waddr,
    output logic [sia_pkg::ID_W-1:0]   o_stack_wdata,
    input  logic                       i_valid_rdata,
    input  logic [sia_pkg::ID_W-1:0]   i_stack_rdata,
    output logic                       o_res_valid,
    output sia_pkg::t_status           o_res_status,
    output logic [sia_pkg::ID_W-1:0]   o_res_id,
    output logic [sia_pkg::USED_W-1:0] o_res_used,
    output logic [sia_pkg::ID_W-1:0]   o_res_free
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > sia_pkg::ID_W) ? CW : sia_pkg::ID_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [WW-1:0] CAP_W = WW'(CAPACITY);

    sia_pkg::t_state r_state, n_state;
    logic [CW-1:0]           r_top, n_top;
    logic [CW-1:0]           r_depth, n_depth;
    logic                    r_op;
    logic [sia_pkg::ID_W-1:0] r_id;

    logic [WW-1:0] id_w;
    logic [WW-1:0] top_w;
    logic [WW-1:0] got_w;

    assign id_w  = WW'(r_id);
    assign top_w = WW'(r_top);
    assign got_w = WW'(i_stack_rdata);

    // read both memories as the transaction is taken
    assign o_valid_raddr = AW'(WW'(i_slot_id));
    assign o_stack_raddr = AW'(r_depth - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sia_pkg::S_IDLE;
            r_top   <= '0;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op <= i_op;
            r_id <= i_slot_id;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sia_pkg::S_IDLE: if (i_accept) n_state = sia_pkg::S_EXEC;
            sia_pkg::S_EXEC: n_state = sia_pkg::S_IDLE;
            default:         n_state = sia_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = (r_state == sia_pkg::S_EXEC);
        o_res_valid   = o_busy;
        n_top         = r_top;
        n_depth       = r_depth;
        o_wr          = '0;
        o_valid_waddr = AW'(id_w);
        o_stack_waddr = AW'(r_depth);
        o_stack_wdata = r_id;
        o_res_status  = sia_pkg::ST_REJECT;
        o_res_id      = r_id;
        if (o_busy) begin
            if (r_op == sia_pkg::OP_ALLOC) begin
                if (r_depth != '0) begin
                    n_depth       = r_depth - CW'(1);
                    o_res_status  = sia_pkg::ST_DONE;
                    o_res_id      = i_stack_rdata;
                    o_valid_waddr = AW'(got_w);
                    o_wr.valid_we = (got_w < CAP_W);
                    o_wr.valid_wd = 1'b1;
                end else if (r_top < CAP_C) begin
                    n_top         = r_top + CW'(1);
                    o_res_status  = sia_pkg::ST_DONE;
                    o_res_id      = sia_pkg::ID_W'(top_w);
                    o_valid_waddr = AW'(top_w);
                    o_wr.valid_we = 1'b1;
                    o_wr.valid_wd = 1'b1;
                end
            end else begin
                if (id_w >= top_w || id_w >= CAP_W) begin
                    o_res_status = sia_pkg::ST_REJECT;
                end else if (!i_valid_rdata) begin
                    o_res_status = sia_pkg::ST_ALREADY_FREE;
                end else begin
                    o_res_status  = sia_pkg::ST_DONE;
                    o_wr.valid_we = 1'b1;
                    o_wr.valid_wd = 1'b0;
                    if (id_w == top_w - WW'(1)) begin
                        n_top = r_top - CW'(1);
                    end else if (r_depth < CAP_C) begin
                        o_wr.stack_we = 1'b1;
                        n_depth       = r_depth + CW'(1);
                    end
                end
            end
        end
        o_res_used = sia_pkg::USED_W'(n_top);
        o_res_free = sia_pkg::ID_W'(n_depth);
    end

endmodule

[sv/sia_checker.sv]
// Port-level checker for the slot identifier allocator, bound to the top level.
module sia_checker #(
    parameter int CAPACITY = sia_pkg::DEF_CAPACITY
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [sia_pkg::STAT_W-1:0] o_status,
    input logic [sia_pkg::USED_W-1:0] o_used_count
);

    localparam logic [sia_pkg::USED_W:0] CAP_U = (sia_pkg::USED_W + 1)'(CAPACITY);

    a_take_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_valid)
        else $error("execute cycle not followed by a result strobe");

    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes in back-to-back cycles");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == sia_pkg::ST_DONE || o_status == sia_pkg::ST_REJECT ||
                    o_status == sia_pkg::ST_ALREADY_FREE)
        else $error("result carries an undefined status code");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, o_used_count} <= CAP_U)
        else $error("used count above capacity");

endmodule

bind slot_id_allocator_with_holes sia_checker #(.CAPACITY(CAPACITY)) u_sia_checker (.*);

[verif/slot_id_allocator_with_holes_tb.sv]
// Self-checking testbench for the slot identifier allocator with a stack of freed slots.
module slot_id_allocator_with_holes_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP         = sia_pkg::DEF_CAPACITY;
    localparam int RESET_CYC   = 7;
    localparam int DRAIN_CYC   = 8;     // drain time after the last result, to catch stray strobes
    localparam int STALL_LIMIT = 3000;  // far past the longest sender gap that pick_gap draws
    localparam int RAND_ITEMS  = 383;   // plus the directed requests, about 400 in all

    // One allocate or free request as it goes out on the command ports.
    typedef struct packed {
        logic                     op;
        logic [sia_pkg::ID_W-1:0] id;
    } t_slot_req;

    // One result as the block should show it on its result ports.
    typedef struct packed {
        sia_pkg::t_status           status;
        logic [sia_pkg::ID_W-1:0]   given_id;
        logic [sia_pkg::USED_W-1:0] used;
        logic [sia_pkg::ID_W-1:0]   stacked;
    } t_slot_result;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       start        = 1'b0;
    logic                       i_op         = sia_pkg::OP_ALLOC;
    logic [sia_pkg::ID_W-1:0]   i_slot_id    = '0;
    logic                       busy;
    logic                       o_valid;
    logic [sia_pkg::STAT_W-1:0] o_status;
    logic [sia_pkg::ID_W-1:0]   o_given_id;
    logic [sia_pkg::USED_W-1:0] o_used_count;
    logic [sia_pkg::ID_W-1:0]   o_free_count;

    t_slot_req    alloc_reqs[$];   // requests not yet handed to the block
    t_slot_result due_results[$];  // results owed by the block, oldest first

    // Shadow of the allocator state, advanced once per accepted transaction.
    bit                       slot_held[CAP];
    logic [sia_pkg::ID_W-1:0] freed_ids[CAP];
    int                       stack_depth = 0;
    int                       top_used    = 0;

    int gap_left     = 0;  // idle cycles still owed before the next request
    int calm_items   = 0;  // requests left in a stretch with no idling
    int stall_cycles = 0;
    bit failed       = 1'b0;

    slot_id_allocator_with_holes #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_slot_id   (i_slot_id),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_given_id  (o_given_id),
        .o_used_count(o_used_count),
        .o_free_count(o_free_count)
    );

    always #2 i_clk = ~i_clk;

    // Advance the shadow state by one request and return the result it owes.
    // Allocate pops the most recent hole first, then grows the used count.
    // A freed top slot only lowers the count; holes below it stay stacked
    // and are handed out again later even if they end up at the top.
    function automatic t_slot_result apply_slot_op(logic op, logic [sia_pkg::ID_W-1:0] id);
        t_slot_result r;
        int           got;
        r.status   = sia_pkg::ST_DONE;
        r.given_id = id;
        if (op == sia_pkg::OP_ALLOC) begin
            if (stack_depth > 0) begin
                stack_depth--;
                got = int'(freed_ids[stack_depth]);
                slot_held[got] = 1'b1;
                r.given_id = got[sia_pkg::ID_W-1:0];
            end else if (top_used < CAP) begin
                got = top_used;
                slot_held[got] = 1'b1;
                top_used++;
                r.given_id = got[sia_pkg::ID_W-1:0];
            end else begin
                // full: state untouched, id echoed
                r.status = sia_pkg::ST_REJECT;
            end
        end else if (int'(id) >= top_used) begin
            r.status = sia_pkg::ST_REJECT;
        end else if (!slot_held[id]) begin
            r.status = sia_pkg::ST_ALREADY_FREE;
        end else begin
            slot_held[id] = 1'b0;
            if (int'(id) == top_used - 1) begin
                top_used--;
            end else if (stack_depth < CAP) begin
                freed_ids[stack_depth] = id;
                stack_depth++;
            end
        end
        r.used    = top_used[sia_pkg::USED_W-1:0];
        r.stacked = stack_depth[sia_pkg::ID_W-1:0];
        return r;
    endfunction

    // Draw the idle time before the next request: mostly short, a few long,
    // with the odd stretch of back-to-back requests.
    function automatic int pick_gap();
        int roll;
        if (calm_items > 0) begin
            calm_items--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm_items = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_req(logic op, int id);
        t_slot_req r;
        r.op = op;
        r.id = id[sia_pkg::ID_W-1:0];
        alloc_reqs.push_back(r);
    endtask

    // Driver: a transaction is taken at an edge where start is high and busy
    // low. Hold the request until then, predict its result on acceptance,
    // then either idle for a drawn gap or present the next request at once.
    always @(posedge i_clk) begin : drive_blk
        t_slot_req nxt;
        bit        taken;
        int        wait_left;
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_op      <= sia_pkg::OP_ALLOC;
            i_slot_id <= '0;
            gap_left  <= 0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                due_results.push_back(apply_slot_op(i_op, i_slot_id));
                wait_left = pick_gap();
            end else begin
                wait_left = gap_left;
            end
            if (start && !taken) begin
                // hold the request steady until the block takes it
            end else if (wait_left > 0 || alloc_reqs.size() == 0) begin
                // idle: drop start and scramble the payload, which must be ignored
                start     <= 1'b0;
                i_op      <= 1'($urandom_range(0, 1));
                i_slot_id <= sia_pkg::ID_W'($urandom_range(0, CAP - 1));
                gap_left  <= (wait_left > 0) ? wait_left - 1 : 0;
            end else begin
                nxt = alloc_reqs.pop_front();
                start     <= 1'b1;
                i_op      <= nxt.op;
                i_slot_id <= nxt.id;
                gap_left  <= 0;
            end
        end
    end

    // Monitor: each strobed result is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_blk
        t_slot_result exp_r;
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                $error("result with nothing expected: status %0d given_id %0d",
                       o_status, o_given_id);
                failed = 1'b1;
            end else begin
                exp_r = due_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                    failed = 1'b1;
                end
                if (o_given_id !== exp_r.given_id) begin
                    $error("given_id: expected %0d, actual %0d", exp_r.given_id, o_given_id);
                    failed = 1'b1;
                end
                if (o_used_count !== exp_r.used) begin
                    $error("used_count: expected %0d, actual %0d", exp_r.used, o_used_count);
                    failed = 1'b1;
                end
                if (o_free_count !== exp_r.stacked) begin
                    $error("free_count: expected %0d, actual %0d", exp_r.stacked, o_free_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("slot_id_allocator_with_holes regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stim_blk
        int gen_top;
        int roll;
        int id;

        // Directed: empty-table reject, growth, holes, double free, top free
        // with a hole below it, out-of-range frees and reuse from the stack.
        push_req(sia_pkg::OP_FREE, 0);            // nothing handed out yet
        push_req(sia_pkg::OP_ALLOC, CAP - 1);     // payload ignored on allocate
        push_req(sia_pkg::OP_ALLOC, 0);
        push_req(sia_pkg::OP_ALLOC, 0);
        push_req(sia_pkg::OP_ALLOC, 0);           // slots 0..3 in use
        push_req(sia_pkg::OP_FREE, 1);            // hole, goes on the stack
        push_req(sia_pkg::OP_FREE, 1);            // already free
        push_req(sia_pkg::OP_FREE, 2);            // second hole
        push_req(sia_pkg::OP_FREE, 3);            // top slot: count drops, holes stay stacked
        push_req(sia_pkg::OP_FREE, 2);            // free hole now at the top edge
        push_req(sia_pkg::OP_FREE, 3);            // at the count: out of range
        push_req(sia_pkg::OP_FREE, CAP - 1);      // far out of range
        push_req(sia_pkg::OP_ALLOC, 0);           // reuse 2
        push_req(sia_pkg::OP_ALLOC, 0);           // reuse 1
        push_req(sia_pkg::OP_ALLOC, 0);           // stack empty: hands out 3
        push_req(sia_pkg::OP_FREE, 0);            // lowest slot as a hole
        push_req(sia_pkg::OP_ALLOC, CAP - 1);     // reuse 0

        // Random mix, frees aimed mostly at slots likely in use.
        gen_top = 4;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                push_req(sia_pkg::OP_ALLOC, $urandom_range(0, CAP - 1));
                if (gen_top < CAP) gen_top++;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70 && gen_top > 0) begin
                    id = (roll < 20) ? gen_top - 1 : $urandom_range(0, gen_top - 1);
                end else if (roll < 85) begin
                    id = $urandom_range(0, CAP - 1);
                end else begin
                    id = gen_top + $urandom_range(0, 2) - 1;
                    if (id < 0) id = 0;
                    if (id > CAP - 1) id = CAP - 1;
                end
                push_req(sia_pkg::OP_FREE, id);
                if (id == gen_top - 1 && gen_top > 0) gen_top--;
            end
        end

        // Hold reset, then release it at a clock edge.
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every result to arrive,
        // then run on for the drain time to catch stray strobes.
        while (alloc_reqs.size() != 0 || start || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (!failed && due_results.size() == 0) begin
            $display("slot_id_allocator_with_holes regression: pass");
        end else begin
            $display("slot_id_allocator_with_holes regression: fail");
        end
        $finish;
    end

endmodule
